### design/tdfl_pkg.sv
// tdfl_pkg: shared constants, status codes and the result word type
// for the transmit descriptor free list; no dependencies
package tdfl_pkg;

    localparam int QUEUE_DEPTH_DEF  = 256;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int BUFFER_BYTES_DEF = 2048;

    localparam int STATUS_W = 3;
    localparam int ID_W     = 8;
    localparam int SLOT_W   = 8;
    localparam int DLEN_W   = 12;
    localparam int AIDX_W   = 16;
    localparam int FREE_W   = 9;
    localparam int LEN_W    = 16;
    localparam int RID_W    = 16;

    localparam logic [STATUS_W-1:0] STATUS_SENT       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LENGTH = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FREED      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED    = 3'd4;

    localparam logic CMD_SEND   = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     desc_id;
        logic [SLOT_W-1:0]   avail_slot;
        logic [DLEN_W-1:0]   desc_length;
        logic [AIDX_W-1:0]   avail_index_out;
        logic [FREE_W-1:0]   free_left;
    } res_t;

endpackage

### design/tdfl_link_mem.sv
// tdfl_link_mem: next-link memory of the free list, one write port and
// one read port with registered read data; no package dependencies
module tdfl_link_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [AW-1:0] rd_data
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/tdfl_engine.sv
// tdfl_engine: command sequencer for send and return words; holds head,
// count and avail index, reads and writes the link memory; uses tdfl_pkg
module tdfl_engine import tdfl_pkg::*; #(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int IW           = $clog2(QUEUE_DEPTH),
    parameter int CW           = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic             command,
    input  logic [LEN_W-1:0] frame_bytes,
    input  logic [RID_W-1:0] returned_id,
    output logic             rd_en,
    output logic [IW-1:0]    rd_addr,
    input  logic [IW-1:0]    rd_data,
    output logic             wr_en,
    output logic [IW-1:0]    wr_addr,
    output logic [IW-1:0]    wr_data,
    output logic             busy,
    output logic             done,
    output res_t             res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam logic [LEN_W:0]  BUF_LIM  = (LEN_W+1)'(BUFFER_BYTES);
    localparam logic [LEN_W:0]  HDR      = (LEN_W+1)'(HEADER_BYTES);
    localparam logic [CW-1:0]   CNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic [RID_W-1:0] RID_LIM = RID_W'(QUEUE_DEPTH);
    localparam logic [IW-1:0]   SLOT_MAX = IW'(QUEUE_DEPTH - 1);

    logic              state_reg, state_next;
    logic              cmd_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [RID_W-1:0]  rid_reg;
    logic [IW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AIDX_W-1:0] aidx_reg, aidx_next;
    logic [IW-1:0]     slot_reg, slot_next;
    logic              done_reg;
    res_t              res_reg, res_next;

    logic [LEN_W:0]    total;
    logic              bad_len;
    logic              exec;

    assign exec    = (state_reg == ST_EXEC);
    assign total   = {1'b0, len_reg} + HDR;
    assign bad_len = (len_reg == '0) || (total > BUF_LIM);

    // read the link after the head while the word is latched
    assign rd_en   = go;
    assign rd_addr = head_reg;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        aidx_next  = aidx_reg;
        slot_next  = slot_reg;
        wr_en      = 1'b0;
        wr_addr    = rid_reg[IW-1:0];
        wr_data    = head_reg;
        res_next.status      = STATUS_IGNORED;
        res_next.desc_id     = '0;
        res_next.avail_slot  = '0;
        res_next.desc_length = '0;
        if (cmd_reg == CMD_SEND)
        begin
            priority if (bad_len)
            begin
                res_next.status = STATUS_BAD_LENGTH;
            end
            else if (count_reg == '0)
            begin
                res_next.status = STATUS_QUEUE_FULL;
            end
            else
            begin
                res_next.status      = STATUS_SENT;
                res_next.desc_id     = ID_W'(head_reg);
                res_next.avail_slot  = SLOT_W'(slot_reg);
                res_next.desc_length = DLEN_W'(total);
                head_next  = rd_data;
                count_next = count_reg - 1'b1;
                aidx_next  = aidx_reg + 1'b1;
                // slot follows avail index mod depth, also across the 16-bit wrap
                if (aidx_next == '0 || slot_reg == SLOT_MAX)
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
        end
        else if (rid_reg < RID_LIM && count_reg < CNT_FULL)
        begin
            res_next.status = STATUS_FREED;
            wr_en      = exec;
            head_next  = rid_reg[IW-1:0];
            count_next = count_reg + 1'b1;
        end
        res_next.avail_index_out = aidx_next;
        res_next.free_left       = FREE_W'(count_next);
        state_next = exec ? ST_IDLE : (go ? ST_EXEC : ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= CNT_FULL;
            aidx_reg  <= '0;
            slot_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (exec)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
                aidx_reg  <= aidx_next;
                slot_reg  <= slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            cmd_reg <= command;
            len_reg <= frame_bytes;
            rid_reg <= returned_id;
        end
        if (exec)
        begin
            res_reg <= res_next;
        end
    end

    assign busy = exec;
    assign done = done_reg;
    assign res  = res_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == ST_EXEC)
        else $error("result strobe without an executed word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("free count above queue depth");

    a_no_go_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        exec |-> !go)
        else $error("word accepted while executing");

    a_sent_pops_one: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.status == STATUS_SENT |->
            CW'(count_reg + 1'b1) == $past(count_reg))
        else $error("send did not take exactly one descriptor");

    a_freed_pushes_head: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.status == STATUS_FREED |->
            head_reg == $past(rid_reg[IW-1:0]))
        else $error("freed id is not the new head");

endmodule

### design/tx_descriptor_free_list_top.sv
// tx_descriptor_free_list_top: top level with the link memory initialising
// sweep; uses tdfl_pkg, tdfl_link_mem and tdfl_engine
//
//  channel   handshake          payload
//  --------  -----------------  ------------------------------------------
//  command   start / busy       command, frame_bytes, returned_id
//  result    done (one cycle)   status, desc_id, avail_slot, desc_length,
//                               avail_index_out, free_left
//
// a word is executed in the EXEC state; the link after the head is read out of the
// synchronous link memory at the same edge that latches the word
// done pulses for one cycle, registered from the EXEC state; the
// receiver cannot stall it
// after reset busy stays high while the link
// memory is loaded with entry i -> i+1, last -> 0
module tx_descriptor_free_list_top import tdfl_pkg::*; #(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [LEN_W-1:0]    frame_bytes,
    input  logic [RID_W-1:0]    returned_id,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     desc_id,
    output logic [SLOT_W-1:0]   avail_slot,
    output logic [DLEN_W-1:0]   desc_length,
    output logic [AIDX_W-1:0]   avail_index_out,
    output logic [FREE_W-1:0]   free_left
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_ID = IW'(QUEUE_DEPTH - 1);

    logic          init_busy_reg;
    logic [IW-1:0] init_cnt_reg;

    logic          go;
    logic          eng_busy;
    logic          rd_en;
    logic [IW-1:0] rd_addr, rd_data;
    logic          eng_wr_en;
    logic [IW-1:0] eng_wr_addr, eng_wr_data;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr, mem_wr_data;
    res_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_cnt_reg  <= '0;
        end
        else if (init_busy_reg)
        begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
            if (init_cnt_reg == LAST_ID)
            begin
                init_busy_reg <= 1'b0;
            end
        end
    end

    assign mem_wr_en   = init_busy_reg | eng_wr_en;
    assign mem_wr_addr = init_busy_reg ? init_cnt_reg : eng_wr_addr;
    assign mem_wr_data = !init_busy_reg ? eng_wr_data :
                         (init_cnt_reg == LAST_ID) ? '0 : init_cnt_reg + 1'b1;

    assign busy = init_busy_reg | eng_busy;
    assign go   = start & ~busy;

    tdfl_link_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (IW)
    ) u_link_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tdfl_engine #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .HEADER_BYTES (HEADER_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES),
        .IW           (IW),
        .CW           (CW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .command     (command),
        .frame_bytes (frame_bytes),
        .returned_id (returned_id),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (eng_wr_en),
        .wr_addr     (eng_wr_addr),
        .wr_data     (eng_wr_data),
        .busy        (eng_busy),
        .done        (done),
        .res         (res)
    );

    assign status          = res.status;
    assign desc_id         = res.desc_id;
    assign avail_slot      = res.avail_slot;
    assign desc_length     = res.desc_length;
    assign avail_index_out = res.avail_index_out;
    assign free_left       = res.free_left;

endmodule
